[design/skve_pkg.sv]
// Shared types, character codes and arithmetic constants for the key value encoder.
// No dependencies; used by skve_decode, skve_fxp_pipe and smc_key_value_encoder.
package skve_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_SCALE = 2'd2;

  localparam logic [15:0] SCALE_RESET = 16'd1000;

  // Type characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_S   = 8'h73;
  localparam logic [7:0] CH_I   = 8'h69;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_P   = 8'h70;
  localparam logic [7:0] CH_8   = 8'h38;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_3   = 8'h33;
  localparam logic [7:0] CH_6   = 8'h36;
  localparam logic [7:0] CH_2   = 8'h32;

  localparam logic [4:0] FP_DIGITS = 5'd16;
  localparam logic [4:0] SP_DIGITS = 5'd15;

  // Fixed-point datapath: (x / 1000) mod 2^16 only needs x mod (125 * 2^19).
  localparam int unsigned FXP_STAGES = 6;
  localparam int unsigned LO_BITS    = 19;
  localparam logic [5:0]  FOLD22     = 6'd54;        // 2^22 mod 125
  localparam logic [3:0]  FOLD14     = 4'd9;         // 2^14 mod 125
  localparam logic [18:0] M125       = 19'd268436;   // ceil(2^25 / 125)
  localparam int unsigned M125_SH    = 25;
  localparam logic [23:0] R125       = 24'd8589935;  // ceil(2^30 / 125)
  localparam int unsigned R125_SH    = 30;
  localparam logic [6:0]  DIV125     = 7'd125;

  typedef struct packed {
    logic        fxp_sel;  // result comes from the fixed-point datapath
    logic        minus;    // reading is negative
    logic [32:0] plain;    // integer or pass-through result
  } skve_side_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'd87;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'd48;
      end
      return d[3:0];
    end
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

[design/skve_decode.sv]
// Type decoder and integer/pass-through encoder for the key value encoder.
// Depends on skve_pkg.
module skve_decode (
  input  logic [31:0]         type_code,
  input  logic [7:0]          value_size,
  input  logic [31:0]         raw_value,
  output skve_pkg::skve_side_t side,
  output logic [31:0]         mag,
  output logic [3:0]          frac_bits
);

  logic [7:0]  c0, c1, c2, c3;
  logic [31:0] int_v;
  logic        int_neg;
  logic [4:0]  digit_sum;
  logic        minus;

  assign c0 = type_code[31:24];
  assign c1 = type_code[23:16];
  assign c2 = type_code[15:8];
  assign c3 = type_code[7:0];

  assign minus     = raw_value[31];
  assign mag       = minus ? (32'd0 - raw_value) : raw_value;
  assign frac_bits = skve_pkg::hex_digit(c3);
  assign digit_sum = {1'b0, skve_pkg::hex_digit(c2)} + {1'b0, frac_bits};

  // unsigned types fold a negative reading to its magnitude
  assign int_v   = (c0 == skve_pkg::CH_U && minus) ? mag : raw_value;
  assign int_neg = minus && (c0 != skve_pkg::CH_U);

  always_comb begin
    side.minus   = minus;
    side.fxp_sel = 1'b0;
    side.plain   = {raw_value[31], raw_value};
    if ((c0 == skve_pkg::CH_U || c0 == skve_pkg::CH_S) && c1 == skve_pkg::CH_I) begin
      unique case (c2)
        skve_pkg::CH_8: begin
          if (c3 == skve_pkg::CH_NUL && value_size == 8'd1) begin
            side.plain = {25'd0, int_neg ? (mag[7:0] | 8'h80) : int_v[7:0]};
          end else begin
            side.plain = {int_v[31], int_v};
          end
        end
        skve_pkg::CH_1: begin
          if (c3 == skve_pkg::CH_6 && value_size == 8'd2) begin
            side.plain = {17'd0, skve_pkg::swap16(int_neg ? (mag[15:0] | 16'h8000)
                                                          : int_v[15:0])};
          end else begin
            side.plain = {int_v[31], int_v};
          end
        end
        skve_pkg::CH_3: begin
          if (c3 == skve_pkg::CH_2 && value_size == 8'd4) begin
            side.plain = {1'b0, skve_pkg::swap32(int_neg ? (mag | 32'h8000_0000) : int_v)};
          end else begin
            side.plain = {int_v[31], int_v};
          end
        end
        default: begin
          side.plain = 33'd0;
        end
      endcase
    end else if ((c0 == skve_pkg::CH_F || c0 == skve_pkg::CH_S) && c1 == skve_pkg::CH_P) begin
      if (digit_sum == ((c0 == skve_pkg::CH_F) ? skve_pkg::FP_DIGITS : skve_pkg::SP_DIGITS)) begin
        side.fxp_sel = 1'b1;
      end
    end
  end

endmodule

[design/skve_fxp_pipe.sv]
// Six-stage fixed-point datapath: ((mag * scale) << frac_bits) / 1000, low 16 bits.
// Depends on skve_pkg; stage enables come from the top-level pipeline control.
module skve_fxp_pipe (
  input  logic                                clk,
  input  logic [skve_pkg::FXP_STAGES-1:0]     adv,
  input  logic [31:0]                         mag,
  input  logic [15:0]                         value_scale,
  input  logic [3:0]                          frac_bits,
  output logic [15:0]                         quo
);

  localparam int unsigned LO = skve_pkg::LO_BITS;

  logic [47:0] prod;
  logic [62:0] xs;
  logic [43:0] x_hi;
  logic [27:0] f1, f1_next;
  logic [17:0] f2, f2_next, f2b;
  logic [LO-1:0] lo3, lo4, lo5;
  logic [36:0] qm_prod;
  logic [11:0] qm;
  logic [17:0] rem_full;
  logic [22:0] v23, v23_next;
  logic [46:0] quo_prod;

  // stage A: full-width product
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod <= {16'd0, mag} * {32'd0, value_scale};
    end
  end

  // stage B: shift, first fold of the high part mod 125
  assign xs      = {15'd0, prod} << frac_bits;
  assign x_hi    = xs[62:LO];
  assign f1_next = 28'(x_hi[43:22]) * 28'(skve_pkg::FOLD22) + 28'(x_hi[21:0]);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      f1  <= f1_next;
      lo3 <= xs[LO-1:0];
    end
  end

  // stage C: second fold
  assign f2_next = 18'(f1[27:14]) * 18'(skve_pkg::FOLD14) + 18'(f1[13:0]);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      f2  <= f2_next;
      lo4 <= lo3;
    end
  end

  // stage D: quotient of f2 by 125 via reciprocal
  assign qm_prod = 37'(f2) * 37'(skve_pkg::M125);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      qm  <= qm_prod[skve_pkg::M125_SH+11:skve_pkg::M125_SH];
      f2b <= f2;
      lo5 <= lo4;
    end
  end

  // stage E: residue, rebuild x mod 65536000 and drop the factor of 8
  assign rem_full = f2b - 18'(qm) * 18'(skve_pkg::DIV125);
  assign v23_next = {rem_full[6:0], lo5[LO-1:3]};

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      v23 <= v23_next;
    end
  end

  // stage F: divide by 125
  assign quo_prod = 47'(v23) * 47'(skve_pkg::R125);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      quo <= quo_prod[skve_pkg::R125_SH+15:skve_pkg::R125_SH];
    end
  end

endmodule

[design/smc_key_value_encoder.sv]
// Top level of the key value encoder: config registers, pipeline control, output stage.
// Depends on skve_pkg, skve_decode and skve_fxp_pipe.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready; index 0 is
//    type_code, 1 is value_size, 2 is value_scale. Write only while no transaction is
//    in flight.
//  - Input channel (in_valid/in_stall, raw_value): one reading per transaction.
//  - Output channel (out_valid/out_stall, encoded_value): one result per reading, in order.
//  - Eight register stages lie between an accepted input and out_valid: input register,
//    six fixed-point stages, output register. Throughput: one transaction per cycle while
//    out_stall is low. The integer and pass-through results ride along the same stages.
//  - Each stage has its own valid bit and loads when empty or when the next stage
//    moves, so bubbles are squeezed out while the receiver stalls; in_stall rises
//    only once all eight stages hold data and out_stall is high.
//  - Reset (rst, synchronous): empties the pipeline, type_code = 0, value_size = 0,
//    value_scale = 1000.
module smc_key_value_encoder (
  input  logic                          clk,
  input  logic                          rst,
  // config write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skve_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // input readings
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   raw_value,
  // encoded results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [32:0]            encoded_value
);

  localparam int unsigned NSTG = skve_pkg::FXP_STAGES + 2;

  logic [31:0] type_code;
  logic [7:0]  value_size;
  logic [15:0] value_scale;

  logic [NSTG-1:0]      vld;
  logic [NSTG-1:0]      en;
  skve_pkg::skve_side_t side_in;
  skve_pkg::skve_side_t side [NSTG-1];
  logic [31:0]          mag_in, mag;
  logic [3:0]           frac_bits;
  logic [15:0]          quo;
  logic [15:0]          fxp_word;

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_code   <= 32'd0;
      value_size  <= 8'd0;
      value_scale <= skve_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        skve_pkg::REG_TYPE_CODE:   type_code   <= cfg_data;
        skve_pkg::REG_VALUE_SIZE:  value_size  <= cfg_data[7:0];
        skve_pkg::REG_VALUE_SCALE: value_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control: a stage loads when empty or when its successor moves ----
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---- stage 0: decode type, integer result, magnitude ----
  skve_decode u_decode (
    .type_code  (type_code),
    .value_size (value_size),
    .raw_value  (raw_value),
    .side       (side_in),
    .mag        (mag_in),
    .frac_bits  (frac_bits)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= side_in;
      mag     <= mag_in;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // ---- stages 1..6: fixed-point scale, shift, divide by 1000 ----
  skve_fxp_pipe u_fxp (
    .clk         (clk),
    .adv         (en[NSTG-2:1]),
    .mag         (mag),
    .value_scale (value_scale),
    .frac_bits   (frac_bits),
    .quo         (quo)
  );

  // ---- output stage: sign bit, byte swap, select ----
  assign fxp_word = skve_pkg::swap16({quo[15] | side[NSTG-2].minus, quo[14:0]});

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      encoded_value <= side[NSTG-2].fxp_sel ? $signed({17'd0, fxp_word})
                                            : $signed(side[NSTG-2].plain);
    end
  end

`ifndef SYNTH
  // an empty output stage lets every stage move
  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("in_stall high with empty output stage");

  // input is refused only when every stage holds a transaction and the receiver stalls
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("in_stall high with a free stage");

  // an accepted reading lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted reading lost at stage 0");

  // fixed-point results fit in 16 bits
  a_fxp_width: assert property (@(posedge clk) disable iff (rst)
    (en[NSTG-1] && vld[NSTG-2] && side[NSTG-2].fxp_sel) |=> (encoded_value[32:16] == 17'd0))
    else $error("fixed-point result wider than 16 bits");
`endif

endmodule
